// File: design/csem_pkg.sv
`default_nettype none

package csem_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_WAIT   = 2'd0,
        OP_SIGNAL = 2'd1,
        OP_CLOSE  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BLOCKED = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_SAT     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_WAKE
    } t_back_state;

    // decoded command handed from the front to the back
    typedef struct packed {
        logic            valid;
        t_op             op;
        logic [ID_W-1:0] tid;
    } t_cmd;

endpackage

`default_nettype wire

// File: design/csem_front.sv
`default_nettype none

module csem_front #(
    parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [csem_pkg::OP_W-1:0]     i_op,
    input  wire logic [csem_pkg::ID_W-1:0]     i_thread_id,
    output csem_pkg::t_cmd                     o_cmd,
    input  wire logic                          i_pop
);

    localparam int TID_W = (THREAD_ID_BITS < csem_pkg::ID_W) ? THREAD_ID_BITS : csem_pkg::ID_W;
    localparam logic [csem_pkg::ID_W-1:0] TID_MASK = csem_pkg::ID_W'((1 << TID_W) - 1);

    csem_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_fill, n_fill;
    csem_pkg::t_op  dec_op;
    logic           push;
    logic           pop;

    always_comb begin
        case (i_op)
            csem_pkg::OP_WAIT:   dec_op = csem_pkg::OP_WAIT;
            csem_pkg::OP_SIGNAL: dec_op = csem_pkg::OP_SIGNAL;
            csem_pkg::OP_CLOSE:  dec_op = csem_pkg::OP_CLOSE;
            default:             dec_op = csem_pkg::OP_NONE;
        endcase
    end

    assign o_ready = (r_fill != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_fill != 2'd0);

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr].valid <= 1'b1;
            r_slot[r_wr_ptr].op    <= dec_op;
            r_slot[r_wr_ptr].tid   <= i_thread_id & TID_MASK;
        end
    end

    always_comb begin
        o_cmd       = r_slot[r_rd_ptr];
        o_cmd.valid = (r_fill != 2'd0);
    end

endmodule

`default_nettype wire

// File: design/csem_back.sv
`default_nettype none

module csem_back #(
    parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [csem_pkg::COUNT_W-1:0]     i_cfg_data,
    input  wire csem_pkg::t_cmd                   i_cmd,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [csem_pkg::STATUS_W-1:0]         o_status,
    output logic                                  o_wake_valid,
    output logic [csem_pkg::ID_W-1:0]             o_wake_thread,
    output logic                                  o_last
);

    localparam int TID_W = (THREAD_ID_BITS < csem_pkg::ID_W) ? THREAD_ID_BITS : csem_pkg::ID_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = csem_pkg::ID_W;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [TID_W-1:0]             r_mem [QUEUE_DEPTH];
    logic [TID_W-1:0]             r_rd_data;

    csem_pkg::t_back_state        r_state, n_state;
    logic [csem_pkg::COUNT_W-1:0] r_init;
    logic [csem_pkg::COUNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0]             r_wcnt, n_wcnt;
    logic [PTR_W-1:0]             r_head, n_head;
    logic [PTR_W-1:0]             r_tail, n_tail;
    logic                         r_close, n_close;

    logic                         r_out_valid;
    csem_pkg::t_status            r_out_status;
    logic                         r_out_wake;
    logic [OUT_W-1:0]             r_out_tid;
    logic                         r_out_last;

    logic                         out_free;
    logic                         emit;
    csem_pkg::t_status            e_status;
    logic                         e_wake;
    logic [OUT_W-1:0]             e_tid;
    logic                         e_last;
    logic                         mem_we;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_wcnt   = r_wcnt;
        n_head   = r_head;
        n_tail   = r_tail;
        n_close  = r_close;
        mem_we   = 1'b0;
        o_pop    = 1'b0;
        emit     = 1'b0;
        e_status = csem_pkg::STAT_OK;
        e_wake   = 1'b0;
        e_tid    = '0;
        e_last   = 1'b1;
        case (r_state)
            csem_pkg::BK_IDLE: begin
                if (i_cmd.valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        csem_pkg::OP_WAIT: begin
                            emit = 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end else if (r_wcnt == CNT_W'(QUEUE_DEPTH)) begin
                                e_status = csem_pkg::STAT_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                n_tail   = next_slot(r_tail);
                                n_wcnt   = r_wcnt + 1'b1;
                                e_status = csem_pkg::STAT_BLOCKED;
                            end
                        end
                        csem_pkg::OP_SIGNAL: begin
                            if (r_wcnt != '0 && r_count == '0) begin
                                // head entry is in the read register by the wake cycle
                                n_close = 1'b0;
                                n_state = csem_pkg::BK_WAKE;
                            end else if (r_count == csem_pkg::COUNT_MAX) begin
                                emit     = 1'b1;
                                e_status = csem_pkg::STAT_SAT;
                            end else begin
                                emit    = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        csem_pkg::OP_CLOSE: begin
                            if (r_wcnt == '0) begin
                                emit    = 1'b1;
                                n_head  = '0;
                                n_tail  = '0;
                                n_count = r_init;
                            end else begin
                                n_close = 1'b1;
                                n_state = csem_pkg::BK_WAKE;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            csem_pkg::BK_FETCH: begin
                n_state = csem_pkg::BK_WAKE;
            end
            csem_pkg::BK_WAKE: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_wake = 1'b1;
                    e_tid  = OUT_W'(r_rd_data);
                    n_head = next_slot(r_head);
                    n_wcnt = r_wcnt - 1'b1;
                    n_state = csem_pkg::BK_IDLE;
                    if (r_close) begin
                        e_last = (r_wcnt == CNT_W'(1));
                        if (r_wcnt == CNT_W'(1)) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_wcnt  = '0;
                            n_count = r_init;
                            n_close = 1'b0;
                        end else begin
                            // the fetch state lets the read register load the new head
                            n_state = csem_pkg::BK_FETCH;
                        end
                    end
                end
            end
            default: begin
                n_state = csem_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csem_pkg::BK_IDLE;
            r_init  <= '0;
            r_count <= '0;
            r_wcnt  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wcnt  <= n_wcnt;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_close <= n_close;
            if (i_cfg_we) begin
                r_init <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_cmd.tid[TID_W-1:0];
        end
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= e_status;
            r_out_wake   <= e_wake;
            r_out_tid    <= e_tid;
            r_out_last   <= e_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_wake_valid  = r_out_wake;
    assign o_wake_thread = r_out_tid;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

// File: design/counting_semaphore_wait_queue.sv
`default_nettype none

// Counting semaphore with a FIFO of blocked thread ids. Ops enter on the s_axis
// side (tuser = op, tdata = thread id), go through a two-entry command queue,
// and are executed one at a time by the back end, which owns the count, the
// waiter memory and a registered result stage on m_axis. A wait, a signal that
// wakes nobody, or op 3 gives a single result; a signal that wakes a waiter
// takes the id from the registered read port of the waiter memory. A close with
// no waiters gives one result; otherwise it releases every waiter, one result
// each with tlast on the final one. Either way it reloads the count from
// initial_count. initial_count is written on the cfg channel, which is always
// ready, and only takes effect at the next close.
module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csem_pkg::THREAD_ID_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [csem_pkg::COUNT_W-1:0] i_cfg_data,    // initial_count
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // [7:0] thread_id
    input  wire logic [1:0]                   s_axis_tuser,  // [1:0] op
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [7:0] wake_thread
    output logic [2:0]                        m_axis_tuser,  // [1:0] status, [2] wake_valid
    output logic                              m_axis_tlast   // last
);

    csem_pkg::t_cmd cmd;
    logic           cmd_pop;

    assign o_cfg_ready = 1'b1;

    csem_front #(
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_thread_id (s_axis_tdata),
        .o_cmd       (cmd),
        .i_pop       (cmd_pop)
    );

    csem_back #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_pop         (cmd_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_status      (m_axis_tuser[1:0]),
        .o_wake_valid  (m_axis_tuser[2]),
        .o_wake_thread (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: design/csem_checker.sv
`default_nettype none

module csem_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [2:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // no released thread means a zero id
    a_idle_tid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata == 8'd0)
        else $error("thread id without wake");

    // only ok results release a thread
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == csem_pkg::STAT_OK)
        else $error("wake with error status");

    // only a close drain gives non-final results, each one a wake
    a_multi_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2])
        else $error("non-final result without wake");

endmodule

bind counting_semaphore_wait_queue csem_checker u_csem_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
